### rtl/ssps_pkg.sv
// ----------------------------------------------------------------------------
// ssps_pkg
// Shared types and constants for the servo sweep pass sequencer.
// ----------------------------------------------------------------------------
package ssps_pkg;

   // request codes carried in req_type
   typedef enum logic [2:0] {
      REQ_TICK      = 3'd0,
      REQ_RESET     = 3'd1,
      REQ_SWEEP_ON  = 3'd2,
      REQ_SWEEP_OFF = 3'd3,
      REQ_SET_ANGLE = 3'd4
   } req_code_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_STEP_PERIOD = 2'd0,
      CSR_STEP_DEG    = 2'd1,
      CSR_SPINUP_HOLD = 2'd2,
      CSR_FAN_PCT     = 2'd3
   } csr_index_type;

   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [15:0] STEP_PERIOD_RST = 16'd1000;
   localparam logic [7:0]  STEP_DEG_RST    = 8'd5;
   localparam logic [15:0] SPINUP_HOLD_RST = 16'd5000;
   localparam logic [6:0]  FAN_PCT_RST     = 7'd100;

   localparam logic [6:0]  FAN_DUTY_MAX    = 7'd100;
   localparam logic [15:0] COUNT_TOP       = 16'hFFFF;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [15:0] angle_request;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  angle_now;
      logic [15:0] pass_count;
      logic        fan_on;
      logic [6:0]  fan_duty;
      logic        hold_active;
      logic        pass_done;
   } rsp_word_type;

endpackage

### rtl/servo_sweep_pass_sequencer_unit.sv
// ----------------------------------------------------------------------------
// servo_sweep_pass_sequencer_unit
// Servo sweep sequencer with pass counting, fan enable and spin-up hold.
// ----------------------------------------------------------------------------
// Usage:
//   req channel takes one word per tick or command (req_valid / req_stall).
//   rsp channel returns exactly one status word per request word, in order.
//   csr port writes step period, step size, spin-up hold and fan duty; write
//   only while no request is in flight.
// Path: a taken request word goes into the request register; the state update
//   then writes its status word into the response register, which drives rsp.
// Throughput: one word per cycle when rsp_stall is low; sweep state is read
//   and written in the same cycle by the update stage, so no bubble is needed.
// Reset: sweep on, angle 0, moving up, count and hold cleared, registers back
//   to their defaults, both pipeline stages empty.
// Stall: when rsp_stall holds a word, the request register fills and then
//   req_stall rises; nothing is dropped and the held word stays stable.
// ----------------------------------------------------------------------------
module servo_sweep_pass_sequencer_unit
   import ssps_pkg::*;
#(
   parameter int ANGLE_MAX = 180
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_data,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic signed [9:0] AngleMaxS = 10'(ANGLE_MAX);
   localparam logic [15:0]       AngleMaxW = 16'(ANGLE_MAX);
   localparam logic [7:0]        AngleMaxB = 8'(ANGLE_MAX);

   // configuration
   logic [15:0] step_period_ff;
   logic [7:0]  step_deg_ff;
   logic [15:0] spinup_hold_ff;
   logic [6:0]  fan_pct_ff;

   // pipeline
   logic         s1_valid_ff;
   req_word_type s1_word_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // sweep state
   logic [7:0]  angle_ff, angle_in;
   logic        down_ff, down_in;
   logic [15:0] pass_ff, pass_in;
   logic        sweep_ff, sweep_in;
   logic [15:0] hold_ff, hold_in;
   logic        pending_ff, pending_in;
   logic [15:0] tss_ff, tss_in;

   logic        out_ready, s1_move;
   logic        done;
   logic [15:0] tss_inc, hold_dec;
   logic signed [9:0] step_next;
   logic [6:0]  duty;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_period_ff <= STEP_PERIOD_RST;
         step_deg_ff    <= STEP_DEG_RST;
         spinup_hold_ff <= SPINUP_HOLD_RST;
         fan_pct_ff     <= FAN_PCT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_STEP_PERIOD: step_period_ff <= csr_wdata;
            CSR_STEP_DEG:    step_deg_ff    <= csr_wdata[7:0];
            CSR_SPINUP_HOLD: spinup_hold_ff <= csr_wdata;
            CSR_FAN_PCT:     fan_pct_ff     <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         angle_ff     <= '0;
         down_ff      <= 1'b0;
         pass_ff      <= '0;
         sweep_ff     <= 1'b1;
         hold_ff      <= '0;
         pending_ff   <= 1'b0;
         tss_ff       <= '0;
      end else begin
         if (!req_stall)
            s1_valid_ff <= req_valid;
         if (out_ready)
            rsp_valid_ff <= s1_valid_ff;
         if (s1_move) begin
            angle_ff   <= angle_in;
            down_ff    <= down_in;
            pass_ff    <= pass_in;
            sweep_ff   <= sweep_in;
            hold_ff    <= hold_in;
            pending_ff <= pending_in;
            tss_ff     <= tss_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall)
         s1_word_ff <= req_data;
      if (s1_move)
         rsp_word_ff <= rsp_word_in;
   end

   assign tss_inc   = (tss_ff == COUNT_TOP) ? tss_ff : tss_ff + 16'd1;
   assign hold_dec  = (hold_ff != '0) ? hold_ff - 16'd1 : hold_ff;
   assign step_next = down_ff ? $signed({2'b00, angle_ff}) - $signed({2'b00, step_deg_ff})
                              : $signed({2'b00, angle_ff}) + $signed({2'b00, step_deg_ff});
   assign duty      = (fan_pct_ff > FAN_DUTY_MAX) ? FAN_DUTY_MAX : fan_pct_ff;

   always_comb begin
      angle_in   = angle_ff;
      down_in    = down_ff;
      pass_in    = pass_ff;
      sweep_in   = sweep_ff;
      hold_in    = hold_ff;
      pending_in = pending_ff;
      tss_in     = tss_ff;
      done       = 1'b0;

      unique case (s1_word_ff.req_type)
         REQ_TICK: begin
            tss_in  = tss_inc;
            hold_in = hold_dec;
            if (sweep_ff) begin
               if (pending_ff) begin
                  // hold expiry restarts the step period without stepping
                  if (hold_dec == '0) begin
                     pending_in = 1'b0;
                     tss_in     = '0;
                  end
               end else if (tss_inc >= step_period_ff) begin
                  tss_in = '0;
                  if (step_next >= AngleMaxS) begin
                     angle_in = AngleMaxB;
                     down_in  = 1'b1;
                     done     = 1'b1;
                  end else if (step_next <= 10'sd0) begin
                     angle_in = '0;
                     down_in  = 1'b0;
                     done     = 1'b1;
                  end else begin
                     angle_in = step_next[7:0];
                  end
                  if (done && pass_ff != COUNT_TOP) begin
                     pass_in = pass_ff + 16'd1;
                     // spin-up hold only on the first pass
                     if (pass_ff == '0) begin
                        hold_in    = spinup_hold_ff;
                        pending_in = 1'b1;
                     end
                  end
               end
            end
         end
         REQ_RESET: begin
            angle_in   = '0;
            down_in    = 1'b0;
            pass_in    = '0;
            sweep_in   = 1'b1;
            hold_in    = '0;
            pending_in = 1'b0;
            tss_in     = '0;
         end
         REQ_SWEEP_ON:  sweep_in = 1'b1;
         REQ_SWEEP_OFF: sweep_in = 1'b0;
         REQ_SET_ANGLE: begin
            sweep_in = 1'b0;
            if (s1_word_ff.angle_request[15])
               angle_in = '0;
            else if (s1_word_ff.angle_request > AngleMaxW)
               angle_in = AngleMaxB;
            else
               angle_in = s1_word_ff.angle_request[7:0];
         end
         default: ;
      endcase

      rsp_word_in.angle_now   = angle_in;
      rsp_word_in.pass_count  = pass_in;
      rsp_word_in.fan_on      = (pass_in != '0);
      rsp_word_in.fan_duty    = (pass_in != '0) ? duty : '0;
      rsp_word_in.hold_active = pending_in && (hold_in != '0);
      rsp_word_in.pass_done   = done;
   end

endmodule
